// File: hdl/ithx_pkg.sv
`default_nettype none
package ithx_pkg;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
	localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
	localparam logic [7:0] CHAR_LOW_A = 8'h61;  // 'a'
	localparam logic [7:0] CHAR_LOW_Z = 8'h7a;  // 'z'
	localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
	localparam logic [7:0] HEX_TEN    = 8'd10;

	localparam logic [6:0] BYTE_LAST  = 7'd127;

	// byte positions of the fixed header fields
	localparam logic [6:0] LEN_HI     = 7'd2;
	localparam logic [6:0] LEN_LO     = 7'd3;
	localparam logic [4:0] SRC_WORD   = 5'd3;   // bytes 12..15
	localparam logic [4:0] DST_WORD   = 5'd4;   // bytes 16..19

	typedef enum logic [1:0] {
		PH_HIGH = 2'd0,
		PH_LOW  = 2'd1,
		PH_SEP  = 2'd2,
		PH_SPARE = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] character;
		logic       line_end;
	} char_t;

	typedef struct packed {
		logic [15:0] case_number;
		logic [15:0] total_length;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] source_port;
		logic [15:0] destination_port;
	} hdr_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE)
				d = c - CHAR_ZERO;
			else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
				d = c - CHAR_LOW_A + HEX_TEN;
			else
				d = c - CHAR_UP_A + HEX_TEN;
			hex_value = d[3:0];
		end
	endfunction

endpackage
`default_nettype wire

// File: hdl/ipv4_tcp_hex_header_extractor.sv
// output: a line's last character passes the character register, then its result is loaded into the result register
// throughput: one character per cycle; the character register and the result
// register are one stage each, and only a line end waits for a free result register
// reset: arst_n clears the line state, the line counter and both valid flags
`default_nettype none
module ipv4_tcp_hex_header_extractor import ithx_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  char_valid,
	output logic       char_ready,
	input  wire char_t char_data,
	output logic       hdr_valid,
	input  wire logic  hdr_ready,
	output hdr_t       hdr_data
);

	logic        valid_s1;
	char_t       char_s1;

	phase_t      phase_q;
	logic [6:0]  byte_idx_q;
	logic [3:0]  high_nib_q;
	logic [3:0]  ihl_q;
	logic [15:0] len_q;
	logic [31:0] src_addr_q;
	logic [31:0] dst_addr_q;
	logic [15:0] src_port_q;
	logic [15:0] dst_port_q;
	logic [15:0] case_cnt_q;
	logic        out_valid_q;
	hdr_t        out_q;

	logic        advance;
	logic [3:0]  nib;
	logic [7:0]  byte_val;
	logic [5:0]  port_start;
	logic [7:0]  port_off;
	phase_t      phase_d;
	logic [6:0]  byte_idx_d;
	logic [3:0]  high_nib_d;
	logic [3:0]  ihl_d;
	logic [15:0] len_d;
	logic [31:0] src_addr_d;
	logic [31:0] dst_addr_d;
	logic [15:0] src_port_d;
	logic [15:0] dst_port_d;
	logic [15:0] case_cnt_d;

	// a line end needs the result register free, other characters always pass
	assign advance    = valid_s1 && (!char_s1.line_end || !out_valid_q || hdr_ready);
	assign char_ready = !valid_s1 || advance;
	assign hdr_valid  = out_valid_q;
	assign hdr_data   = out_q;

	assign nib        = hex_value(char_s1.character);
	assign byte_val   = {high_nib_q, nib};

	always_comb begin
		phase_d    = phase_q;
		byte_idx_d = byte_idx_q;
		high_nib_d = high_nib_q;
		ihl_d      = ihl_q;
		len_d      = len_q;
		src_addr_d = src_addr_q;
		dst_addr_d = dst_addr_q;
		src_port_d = src_port_q;
		dst_port_d = dst_port_q;
		port_start = '0;
		port_off   = '0;
		unique case (phase_q)
			PH_LOW: begin
				phase_d = PH_SEP;
				if (byte_idx_q == '0)
					ihl_d = byte_val[3:0];
				port_start = {ihl_d, 2'b00};
				port_off   = {1'b0, byte_idx_q} - {2'b00, port_start};
				if (byte_idx_q == LEN_HI)
					len_d[15:8] = byte_val;
				if (byte_idx_q == LEN_LO)
					len_d[7:0] = byte_val;
				if (byte_idx_q[6:2] == SRC_WORD) begin
					case (byte_idx_q[1:0])
						2'd0:    src_addr_d[31:24] = byte_val;
						2'd1:    src_addr_d[23:16] = byte_val;
						2'd2:    src_addr_d[15:8]  = byte_val;
						default: src_addr_d[7:0]   = byte_val;
					endcase
				end
				if (byte_idx_q[6:2] == DST_WORD) begin
					case (byte_idx_q[1:0])
						2'd0:    dst_addr_d[31:24] = byte_val;
						2'd1:    dst_addr_d[23:16] = byte_val;
						2'd2:    dst_addr_d[15:8]  = byte_val;
						default: dst_addr_d[7:0]   = byte_val;
					endcase
				end
				// index at or past the port start and within four bytes of it
				if (port_off[7:2] == '0) begin
					case (port_off[1:0])
						2'd0:    src_port_d[15:8] = byte_val;
						2'd1:    src_port_d[7:0]  = byte_val;
						2'd2:    dst_port_d[15:8] = byte_val;
						default: dst_port_d[7:0]  = byte_val;
					endcase
				end
			end
			PH_SEP: begin
				phase_d = PH_HIGH;
				if (byte_idx_q != BYTE_LAST)
					byte_idx_d = byte_idx_q + 7'd1;
			end
			default: begin
				// spare phase behaves as a high nibble
				phase_d    = PH_LOW;
				high_nib_d = nib;
			end
		endcase
		case_cnt_d = case_cnt_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid)
			char_s1 <= char_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HIGH;
			byte_idx_q <= '0;
			high_nib_q <= '0;
			ihl_q      <= '0;
			len_q      <= '0;
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
			case_cnt_q <= '0;
		end else if (advance) begin
			if (char_s1.line_end) begin
				phase_q    <= PH_HIGH;
				byte_idx_q <= '0;
				high_nib_q <= '0;
				ihl_q      <= '0;
				len_q      <= '0;
				src_addr_q <= '0;
				dst_addr_q <= '0;
				src_port_q <= '0;
				dst_port_q <= '0;
				case_cnt_q <= case_cnt_d;
			end else begin
				phase_q    <= phase_d;
				byte_idx_q <= byte_idx_d;
				high_nib_q <= high_nib_d;
				ihl_q      <= ihl_d;
				len_q      <= len_d;
				src_addr_q <= src_addr_d;
				dst_addr_q <= dst_addr_d;
				src_port_q <= src_port_d;
				dst_port_q <= dst_port_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && char_s1.line_end) begin
			out_valid_q <= 1'b1;
		end else if (hdr_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && char_s1.line_end) begin
			out_q.case_number         <= case_cnt_d;
			out_q.total_length        <= len_d;
			out_q.source_address      <= src_addr_d;
			out_q.destination_address <= dst_addr_d;
			out_q.source_port         <= src_port_d;
			out_q.destination_port    <= dst_port_d;
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/ipv4_tcp_hex_header_extractor_tb.sv
`default_nettype none
module ipv4_tcp_hex_header_extractor_tb;
	import ithx_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_SPAN    = 300;

	logic  clk;
	logic  arst_n     = 1'b0;
	logic  char_valid = 1'b0;
	logic  char_ready;
	char_t char_data  = '0;
	logic  hdr_valid;
	logic  hdr_ready  = 1'b0;
	hdr_t  hdr_data;

	// header parser state, mirrored from the block
	phase_t      ph;
	logic [6:0]  byte_pos;
	logic [3:0]  nib_hi;
	logic [3:0]  ihl;
	logic [15:0] len_f;
	logic [31:0] src_f;
	logic [31:0] dst_f;
	logic [15:0] sport_f;
	logic [15:0] dport_f;
	logic [15:0] line_count;
	hdr_t        expected_headers[$];

	logic [7:0] line_bytes[$];
	logic [7:0] line_text[$];
	bit         tx_idle;
	bit         rx_idle;
	bit         hold_req;
	int         sent_chars;
	int         sent_lines;
	int         errors;
	int         quiet_cycles;

	ipv4_tcp_hex_header_extractor DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data),
		.hdr_valid (hdr_valid),
		.hdr_ready (hdr_ready),
		.hdr_data  (hdr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_line();
		ph = PH_HIGH;
		byte_pos = '0;
		nib_hi = '0;
		ihl = '0;
		len_f = '0;
		src_f = '0;
		dst_f = '0;
		sport_f = '0;
		dport_f = '0;
	endfunction

	// letters of either case, and anything else, land on the low nibble plus nine
	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		if (c >= CHAR_ZERO && c <= CHAR_NINE)
			return c[3:0];
		return c[3:0] + 4'd9;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		int idx;
		int start;
		idx = byte_pos;
		// ihl from byte 0 already counts for its own port test
		if (idx == 0)
			ihl = b[3:0];
		start = 4 * ihl;
		if (idx == LEN_HI)
			len_f[15:8] = b;
		if (idx == LEN_LO)
			len_f[7:0] = b;
		if (idx >= 12 && idx <= 15)
			src_f[8 * (15 - idx) +: 8] = b;
		if (idx >= 16 && idx <= 19)
			dst_f[8 * (19 - idx) +: 8] = b;
		if (idx == start)
			sport_f[15:8] = b;
		if (idx == start + 1)
			sport_f[7:0] = b;
		if (idx == start + 2)
			dport_f[15:8] = b;
		if (idx == start + 3)
			dport_f[7:0] = b;
	endfunction

	function automatic void parse_char(input char_t item);
		logic [3:0] nib;
		hdr_t done;
		nib = nibble_of(item.character);
		case (ph)
			PH_LOW: begin
				take_byte({nib_hi, nib});
				ph = PH_SEP;
			end
			PH_SEP: begin
				if (byte_pos != BYTE_LAST)
					byte_pos = byte_pos + 7'd1;
				ph = PH_HIGH;
			end
			default: begin
				nib_hi = nib;
				ph = PH_LOW;
			end
		endcase
		if (item.line_end) begin
			line_count = line_count + 16'd1;
			done.case_number = line_count;
			done.total_length = len_f;
			done.source_address = src_f;
			done.destination_address = dst_f;
			done.source_port = sport_f;
			done.destination_port = dport_f;
			expected_headers.push_back(done);
			clear_line();
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10)
			return CHAR_ZERO + nib;
		return ($urandom_range(0, 1) ? CHAR_UP_A : CHAR_LOW_A) + nib - 8'd10;
	endfunction

	function automatic logic [7:0] garble(input logic [7:0] ch, input int noise);
		if ($urandom_range(0, 99) < noise)
			return 8'($urandom);
		return ch;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic last);
		char_t item;
		item.character = ch;
		item.line_end = last;
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_data <= item;
		do @(posedge clk); while (!char_ready);
		parse_char(item);
		sent_chars++;
		if (last)
			sent_lines++;
	endtask

	task automatic send_text();
		if (line_text.size() == 0)
			line_text.push_back(8'($urandom));
		foreach (line_text[i])
			send_char(line_text[i], i == line_text.size() - 1);
	endtask

	task automatic build_text(input int noise);
		line_text.delete();
		foreach (line_bytes[i]) begin
			if (i != 0)
				line_text.push_back(garble(" ", noise));
			line_text.push_back(garble(hex_char(line_bytes[i][7:4]), noise));
			line_text.push_back(garble(hex_char(line_bytes[i][3:0]), noise));
		end
	endtask

	task automatic make_header(input logic [3:0] hw, input int nbytes);
		logic [3:0] ver;
		line_bytes.delete();
		ver = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4;
		line_bytes.push_back({ver, hw});
		for (int i = 1; i < nbytes; i++)
			line_bytes.push_back(8'($urandom));
	endtask

	// stop sending until every pending line has come back
	task automatic drain();
		char_valid <= 1'b0;
		while (expected_headers.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		// line ends on a high nibble, nothing captured
		send_char("F", 1'b1);
		// lower case, ends on the low nibble of byte 0
		send_char("4", 1'b0);
		send_char("f", 1'b1);
		// ends on the separator with ihl zero
		send_char("0", 1'b0);
		send_char("0", 1'b0);
		send_char(" ", 1'b1);
		// odd separator, ihl one moves the ports to byte 4
		send_char("4", 1'b0);
		send_char("1", 1'b0);
		send_char(8'h80, 1'b0);
		send_char("A", 1'b0);
		send_char("b", 1'b1);
		// characters outside the hex set
		send_char(8'h00, 1'b0);
		send_char(8'hff, 1'b0);
		send_char("g", 1'b0);
		send_char("Z", 1'b1);
		// zero ihl puts both ports over bytes 0..3, total length among them
		line_bytes = '{8'h00, 8'h00, 8'h12, 8'h34};
		build_text(0);
		send_text();
	endtask

	task automatic test_random_lines(input int min_chars, input int min_lines);
		int first_chars;
		int first_lines;
		int kind;
		int hw;
		int nbytes;
		first_chars = sent_chars;
		first_lines = sent_lines;
		while (sent_chars - first_chars < min_chars || sent_lines - first_lines < min_lines) begin
			kind = $urandom_range(0, 9);
			// mostly plausible header lengths, the rest any ihl at all
			hw = (kind < 6) ? $urandom_range(5, 7) : $urandom_range(0, 15);
			nbytes = 4 * hw + 4 + $urandom_range(0, 3);
			if (kind == 9)
				nbytes = $urandom_range(1, nbytes);
			make_header(hw[3:0], nbytes);
			build_text((kind == 8) ? 15 : 1);
			if (kind == 7) begin
				repeat ($urandom_range(1, 2))
					if (line_text.size() > 1)
						void'(line_text.pop_back());
			end
			send_text();
		end
	endtask

	task automatic test_input_stall();
		hold_req = 1'b1;
		repeat (12) begin
			make_header(4'($urandom), $urandom_range(1, 4));
			build_text(0);
			send_text();
		end
		drain();
	endtask

	task automatic test_long_line();
		// bytes past 127 pile onto the last index and feed nothing
		make_header(4'hf, 129);
		build_text(2);
		send_text();
	endtask

	task automatic test_single_char_lines();
		repeat (10) send_char(8'($urandom), 1'b1);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : header_check
		hdr_t want;
		if (arst_n && hdr_valid && hdr_ready) begin
			if (expected_headers.size() == 0) begin
				$error("header result with no line pending");
				errors++;
			end else begin
				want = expected_headers.pop_front();
				check_field("case_number", want.case_number, hdr_data.case_number);
				check_field("total_length", want.total_length, hdr_data.total_length);
				check_field("source_address", want.source_address, hdr_data.source_address);
				check_field("destination_address", want.destination_address,
					hdr_data.destination_address);
				check_field("source_port", want.source_port, hdr_data.source_port);
				check_field("destination_port", want.destination_port, hdr_data.destination_port);
			end
		end
	end

	// result side: random stalls, and one long hold when a test requests it
	initial begin : result_sink
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				hdr_ready <= 1'b0;
				repeat (HOLD_SPAN) @(posedge clk);
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				hdr_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				hdr_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (hdr_valid && hdr_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		clear_line();
		line_count = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_directed();
		test_random_lines(80, 1);
		test_input_stall();
		test_long_line();
		// closing stretch runs flat out
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_single_char_lines();
		test_random_lines(60, 1);
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire
